FILE: src/salsa_pkg.sv
`default_nettype none

package salsa_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DR_W    = 7;
    localparam int unsigned QR_W    = 3;

    localparam logic [DR_W-1:0]   DR_RESET  = 7'd4;
    localparam logic [ADDR_W-1:0] LAST_ADDR = 4'd15;
    localparam logic [QR_W-1:0]   LAST_QR   = 3'd7;

    // Quarter-round rotation amounts
    localparam int unsigned ROT_B = 7;
    localparam int unsigned ROT_C = 9;
    localparam int unsigned ROT_D = 13;
    localparam int unsigned ROT_A = 18;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Which word of the quarter round an add-rotate-xor step updates
    typedef enum logic [1:0] {
        STEP_B = 2'd0,
        STEP_C = 2'd1,
        STEP_D = 2'd2,
        STEP_A = 2'd3
    } step_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_AB,
        ST_RD_CD,
        ST_LATCH_CD,
        ST_STEP,
        ST_EMIT_RD,
        ST_EMIT_ADD,
        ST_EMIT_WAIT
    } state_t;

    typedef struct packed {
        logic  load_we;
        addr_t load_addr;
        addr_t rd_addr0;
        addr_t rd_addr1;
        logic  latch_ab;
        logic  latch_cd;
        logic  step_en;
        step_t step;
        addr_t step_addr;
        logic  out_load;
        logic  out_last;
    } ctl_t;

    typedef struct packed {
        addr_t a;
        addr_t b;
        addr_t c;
        addr_t d;
    } qidx_t;

    // Word indexes of the eight quarter rounds of one double round:
    // four column quarters, then four row quarters.
    function automatic qidx_t qr_index(input logic [QR_W-1:0] qr);
        qidx_t q;
        case (qr)
            3'd0:    q = '{4'd0,  4'd4,  4'd8,  4'd12};
            3'd1:    q = '{4'd5,  4'd9,  4'd13, 4'd1};
            3'd2:    q = '{4'd10, 4'd14, 4'd2,  4'd6};
            3'd3:    q = '{4'd15, 4'd3,  4'd7,  4'd11};
            3'd4:    q = '{4'd0,  4'd1,  4'd2,  4'd3};
            3'd5:    q = '{4'd5,  4'd6,  4'd7,  4'd4};
            3'd6:    q = '{4'd10, 4'd11, 4'd8,  4'd9};
            3'd7:    q = '{4'd15, 4'd12, 4'd13, 4'd14};
            default: q = '{4'd0,  4'd4,  4'd8,  4'd12};
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

FILE: src/salsa_if.sv
`default_nettype none

interface salsa_in_if import salsa_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

interface salsa_out_if import salsa_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t hash_word;
    logic  last_word;

    modport source (output valid, output hash_word, output last_word, input ready);
    modport sink   (input valid, input hash_word, input last_word, output ready);
endinterface

`default_nettype wire

FILE: src/salsa_qr_unit.sv
`default_nettype none

// Shared add-rotate-xor unit with the four words of the current quarter round.
module salsa_qr_unit import salsa_pkg::*; (
    input  wire logic  clk,
    input  wire ctl_t  ctl,
    input  wire word_t rd0,
    input  wire word_t rd1,
    output word_t      result
);

    word_t qa_reg;
    word_t qb_reg;
    word_t qc_reg;
    word_t qd_reg;
    word_t sum;
    word_t target;
    word_t rotated;

    always_comb
    begin
        case (ctl.step)
            STEP_B:
            begin
                target  = qb_reg;
                sum     = qa_reg + qd_reg;
                rotated = (sum << ROT_B) | (sum >> (WORD_W - ROT_B));
            end
            STEP_C:
            begin
                target  = qc_reg;
                sum     = qb_reg + qa_reg;
                rotated = (sum << ROT_C) | (sum >> (WORD_W - ROT_C));
            end
            STEP_D:
            begin
                target  = qd_reg;
                sum     = qc_reg + qb_reg;
                rotated = (sum << ROT_D) | (sum >> (WORD_W - ROT_D));
            end
            default:
            begin
                target  = qa_reg;
                sum     = qd_reg + qc_reg;
                rotated = (sum << ROT_A) | (sum >> (WORD_W - ROT_A));
            end
        endcase
    end

    assign result = target ^ rotated;

    always_ff @(posedge clk)
    begin
        if (ctl.latch_ab)
        begin
            qa_reg <= rd0;
            qb_reg <= rd1;
        end
        if (ctl.latch_cd)
        begin
            qc_reg <= rd0;
            qd_reg <= rd1;
        end
        if (ctl.step_en)
        begin
            case (ctl.step)
                STEP_B:  qb_reg <= result;
                STEP_C:  qc_reg <= result;
                STEP_D:  qd_reg <= result;
                default: qa_reg <= result;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/salsa_ctrl.sv
`default_nettype none

// Block sequencer: load, quarter-round schedule, feed-forward emit.
module salsa_ctrl import salsa_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_fire,
    input  wire logic            out_fire,
    input  wire logic [DR_W-1:0] double_rounds,
    output logic                 in_ready,
    output ctl_t                 ctl
);

    state_t           state_reg,     state_next;
    addr_t            load_cnt_reg,  load_cnt_next;
    logic [QR_W-1:0]  qr_cnt_reg,    qr_cnt_next;
    step_t            step_cnt_reg,  step_cnt_next;
    logic [DR_W-1:0]  round_cnt_reg, round_cnt_next;
    addr_t            emit_cnt_reg,  emit_cnt_next;
    logic             last_round;
    logic             no_rounds;
    qidx_t            qidx;

    assign last_round = (DR_W'(round_cnt_reg + 7'd1) == double_rounds);
    assign no_rounds  = (double_rounds == '0);
    assign qidx       = qr_index(qr_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            load_cnt_reg  <= '0;
            qr_cnt_reg    <= '0;
            step_cnt_reg  <= STEP_B;
            round_cnt_reg <= '0;
            emit_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            qr_cnt_reg    <= qr_cnt_next;
            step_cnt_reg  <= step_cnt_next;
            round_cnt_reg <= round_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
        end
    end

    // Counters
    always_comb
    begin
        load_cnt_next  = load_cnt_reg;
        qr_cnt_next    = qr_cnt_reg;
        step_cnt_next  = step_cnt_reg;
        round_cnt_next = round_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                    load_cnt_next = load_cnt_reg + 4'd1;
            end
            ST_STEP:
            begin
                step_cnt_next = step_t'(step_cnt_reg + 2'd1);
                if (step_cnt_reg == STEP_A)
                begin
                    qr_cnt_next = qr_cnt_reg + 3'd1;
                    if (qr_cnt_reg == LAST_QR)
                        round_cnt_next = last_round ? '0 : DR_W'(round_cnt_reg + 7'd1);
                end
            end
            ST_EMIT_WAIT:
            begin
                if (out_fire)
                    emit_cnt_next = emit_cnt_reg + 4'd1;
            end
            default:
            begin
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && load_cnt_reg == LAST_ADDR)
                    state_next = no_rounds ? ST_EMIT_RD : ST_RD_AB;
            end
            ST_RD_AB:    state_next = ST_RD_CD;
            ST_RD_CD:    state_next = ST_LATCH_CD;
            ST_LATCH_CD: state_next = ST_STEP;
            ST_STEP:
            begin
                if (step_cnt_reg == STEP_A)
                begin
                    if (qr_cnt_reg == LAST_QR && last_round)
                        state_next = ST_EMIT_RD;
                    else
                        state_next = ST_RD_AB;
                end
            end
            ST_EMIT_RD:  state_next = ST_EMIT_ADD;
            ST_EMIT_ADD: state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
            begin
                if (out_fire)
                    state_next = (emit_cnt_reg == LAST_ADDR) ? ST_LOAD : ST_EMIT_RD;
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready      = 1'b0;
        ctl           = '0;
        ctl.load_addr = load_cnt_reg;
        ctl.step      = step_cnt_reg;
        ctl.rd_addr0  = emit_cnt_reg;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready    = 1'b1;
                ctl.load_we = in_fire;
            end
            ST_RD_AB:
            begin
                ctl.rd_addr0 = qidx.a;
                ctl.rd_addr1 = qidx.b;
            end
            ST_RD_CD:
            begin
                ctl.rd_addr0 = qidx.c;
                ctl.rd_addr1 = qidx.d;
                ctl.latch_ab = 1'b1;
            end
            ST_LATCH_CD:
            begin
                ctl.latch_cd = 1'b1;
            end
            ST_STEP:
            begin
                ctl.step_en = 1'b1;
                case (step_cnt_reg)
                    STEP_B:  ctl.step_addr = qidx.b;
                    STEP_C:  ctl.step_addr = qidx.c;
                    STEP_D:  ctl.step_addr = qidx.d;
                    default: ctl.step_addr = qidx.a;
                endcase
            end
            ST_EMIT_ADD:
            begin
                ctl.out_load = 1'b1;
                ctl.out_last = (emit_cnt_reg == LAST_ADDR);
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/salsa20_core_hash.sv
// Salsa20 core hash, one shared add-rotate-xor unit.
// The block takes its sixteen request words, then runs every quarter round through the
// single unit: read a,b, read c,d, latch them, then the b, c, d and a add-rotate-xor steps.
// Each result word is summed and held for the sink; a new block is taken only after the last.
// Reset (rst_n low, asynchronous) empties the block, clears the sequencer and
// sets double_rounds to 4 (Salsa20/8); word stores are not cleared.
`default_nettype none

module salsa20_core_hash import salsa_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [DR_W-1:0] cfg_wdata,
    salsa_in_if.sink             data,
    salsa_out_if.source          hash
);

    // Configuration: double rounds; write only while the block is idle (the block does not enforce it)
    logic [DR_W-1:0] double_rounds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            double_rounds_reg <= DR_RESET;
        else if (cfg_we)
            double_rounds_reg <= cfg_wdata;
    end

    // Handshakes
    logic in_ready;
    logic in_fire;
    logic out_fire;

    assign data.ready = in_ready;
    assign in_fire    = data.valid & in_ready;
    assign out_fire   = hash.valid & hash.ready;

    ctl_t ctl;

    salsa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .out_fire      (out_fire),
        .double_rounds (double_rounds_reg),
        .in_ready      (in_ready),
        .ctl           (ctl)
    );

    // Original words: written on load, read back for the feed-forward sum.
    // Working words: loaded with the same request words, then updated one
    // word per step by the quarter-round unit.
    word_t orig_mem [16];
    word_t work_mem [16];
    word_t orig_rd_reg;
    word_t work_rd0_reg;
    word_t work_rd1_reg;
    word_t step_result;

    always_ff @(posedge clk)
    begin
        if (ctl.load_we)
            orig_mem[ctl.load_addr] <= data.data_word;
        orig_rd_reg <= orig_mem[ctl.rd_addr0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_we)
            work_mem[ctl.load_addr] <= data.data_word;
        else if (ctl.step_en)
            work_mem[ctl.step_addr] <= step_result;
        work_rd0_reg <= work_mem[ctl.rd_addr0];
        work_rd1_reg <= work_mem[ctl.rd_addr1];
    end

    salsa_qr_unit u_qr (
        .clk    (clk),
        .ctl    (ctl),
        .rd0    (work_rd0_reg),
        .rd1    (work_rd1_reg),
        .result (step_result)
    );

    // Result register: feed-forward sum, held until the sink takes it
    word_t hash_word_reg;
    logic  last_word_reg;
    logic  out_valid_reg, out_valid_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (out_fire)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            hash_word_reg <= orig_rd_reg + work_rd0_reg;
            last_word_reg <= ctl.out_last;
        end
    end

    assign hash.valid     = out_valid_reg;
    assign hash.hash_word = hash_word_reg;
    assign hash.last_word = last_word_reg;

endmodule

`default_nettype wire

FILE: bench/tb_salsa20_core_hash.sv
`timescale 1ns / 1ps

import salsa_pkg::*;

typedef struct {
    word_t hash_word;
    logic  last_word;
} hash_result_t;

// Tracks the block being loaded and holds the hash words still owed by the DUT.
class salsa_hash_tracker;
    word_t            orig_words[16];
    word_t            mix_words[16];
    logic [ADDR_W-1:0] fill = '0;
    logic [DR_W-1:0]  rounds = DR_RESET;
    hash_result_t     owed_words[$];
    int               failures = 0;
    int               words_taken = 0;
    int               blocks_hashed = 0;
    int               words_checked = 0;

    function word_t rotl(word_t v, int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
        mix_words[b] ^= rotl(mix_words[a] + mix_words[d], 7);
        mix_words[c] ^= rotl(mix_words[b] + mix_words[a], 9);
        mix_words[d] ^= rotl(mix_words[c] + mix_words[b], 13);
        mix_words[a] ^= rotl(mix_words[d] + mix_words[c], 18);
    endfunction

    function void hash_block();
        hash_result_t r;
        mix_words = orig_words;
        repeat (rounds)
        begin
            // columns
            quarter(0, 4, 8, 12);
            quarter(5, 9, 13, 1);
            quarter(10, 14, 2, 6);
            quarter(15, 3, 7, 11);
            // rows
            quarter(0, 1, 2, 3);
            quarter(5, 6, 7, 4);
            quarter(10, 11, 8, 9);
            quarter(15, 12, 13, 14);
        end
        for (int i = 0; i < 16; i++)
        begin
            r.hash_word = orig_words[i] + mix_words[i];
            r.last_word = (i == 15);
            owed_words.insert(owed_words.size(), r);
        end
        blocks_hashed++;
    endfunction

    function void set_rounds(logic [DR_W-1:0] v);
        rounds = v;
    endfunction

    function void take_word(word_t w);
        orig_words[fill] = w;
        words_taken++;
        if (fill == LAST_ADDR)
            hash_block();
        fill = fill + 1'b1;
    endfunction

    function void check_word(word_t h, logic l);
        hash_result_t e;
        if (owed_words.size() == 0)
        begin
            $error("unexpected hash word %h (last_word %b)", h, l);
            failures++;
            return;
        end
        e = owed_words.pop_front();
        words_checked++;
        if (h !== e.hash_word)
        begin
            $error("hash_word expected %h actual %h", e.hash_word, h);
            failures++;
        end
        if (l !== e.last_word)
        begin
            $error("last_word expected %b actual %b", e.last_word, l);
            failures++;
        end
    endfunction

    function int pending();
        return owed_words.size();
    endfunction
endclass

module tb_salsa20_core_hash;

    localparam int LIMIT     = 200_000;   // watchdog limit, in cycles
    localparam int LONG_HOLD = 600;       // forced output hold-off, in cycles
    localparam int SETTLE    = 24;        // quiet cycles before a register write

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [DR_W-1:0] cfg_wdata;

    salsa_in_if  word_in ();
    salsa_out_if hash_out ();

    salsa20_core_hash dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .data      (word_in),
        .hash      (hash_out)
    );

    salsa_hash_tracker tracker = new;

    always #6 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends here.
    initial
    begin : watchdog
        repeat (LIMIT) @(posedge clk);
        $display("tb_salsa20_core_hash NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge; the bench only
    // drives on the falling edge, so the values seen here are settled.
    // Register writes are mirrored into the tracker at the edge that
    // commits them, so a write while a block is still loading is modeled:
    // the value in force at the sixteenth request is used.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (word_in.valid && word_in.ready)
                tracker.take_word(word_in.data_word);
            if (cfg_we)
                tracker.set_rounds(cfg_wdata);
            if (hash_out.valid && hash_out.ready)
                tracker.check_word(hash_out.hash_word, hash_out.last_word);
        end
    end

    // ------------------------------------------------------------------
    // Result side back-pressure. The receiver switches between four
    // ready patterns at random intervals. A long hold-off can be
    // requested by the stimulus; it is counted down here, while the
    // sender keeps offering requests so that the block backs up.
    // ------------------------------------------------------------------
    int rx_hold_reqs = 0;   // bumped by the stimulus
    int rx_hold_seen = 0;
    int rx_hold = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_tick = 0;

    always @(negedge clk)
    begin
        if (rx_hold_seen != rx_hold_reqs)
        begin
            rx_hold_seen = rx_hold_reqs;
            rx_hold = LONG_HOLD;
        end
        rx_tick++;
        if (rx_hold > 0)
        begin
            rx_hold--;
            hash_out.ready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 120);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       hash_out.ready <= 1'b1;                       // never stalls
                1:       hash_out.ready <= 1'($urandom_range(0, 1));   // coin flip
                2:       hash_out.ready <= ((rx_tick % 4) == 0);       // one in four
                default: hash_out.ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request side. Requests go out in bursts of random length; between
    // bursts valid drops for a random gap (often none at all).
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic offer_word(input word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                word_in.valid <= 1'b0;
                word_in.data_word <= $urandom;
            end
        end
        burst_left--;
        @(negedge clk);
        word_in.valid <= 1'b1;
        word_in.data_word <= w;
        do
            @(posedge clk);
        while (!word_in.ready);
    endtask

    // Mostly uniform words, with single-bit, single-hole and flat words mixed in.
    function automatic word_t random_word();
        case ($urandom_range(0, 7))
            0:       return word_t'(1) << $urandom_range(0, 31);
            1:       return ~(word_t'(1) << $urandom_range(0, 31));
            2:       return $urandom_range(0, 1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_block();
        for (int i = 0; i < 16; i++)
            offer_word(random_word());
    endtask

    // Drop valid, wait for every owed hash word, then let the block settle.
    // Also used in mid-block, where nothing is owed but the block is loading.
    task automatic drain();
        @(negedge clk);
        word_in.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Exactly one rising edge sees the write enable high.
    task automatic write_rounds(input logic [DR_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        word_t edge_words[16] = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
            32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555,
            32'h0403_0201, 32'h0807_0605, 32'hDEAD_BEEF, 32'h0000_FFFF,
            32'hFFFF_0000, 32'h00FF_00FF, 32'hFF00_FF00, 32'h1234_5678
        };
        int unsigned phase_rounds[8] = '{10, 127, 1, 0, 2, 7, 0, 0};
        int unsigned phase_blocks[8] = '{2, 1, 2, 2, 2, 1, 1, 1};

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        word_in.valid = 1'b0;
        word_in.data_word = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // Directed: field extremes at the reset setting (Salsa20/8).
        for (int i = 0; i < 16; i++)
            offer_word(edge_words[i]);
        drain();

        // Directed: register changed half way through a block, to zero
        // double rounds, so each hash word must come back as twice its input.
        for (int i = 0; i < 8; i++)
            offer_word('1);
        drain();
        write_rounds('0);
        for (int i = 0; i < 8; i++)
            offer_word(random_word());
        drain();

        // Random blocks over a sweep of round settings, both extremes included.
        phase_rounds[6] = $urandom_range(0, 12);
        phase_rounds[7] = $urandom_range(0, 12);
        for (int p = 0; p < 8; p++)
        begin
            write_rounds(phase_rounds[p][DR_W-1:0]);
            // One short-round phase runs under a long output hold-off, so the
            // result side backs up into the request side.
            if (p == 2)
                rx_hold_reqs++;
            repeat (phase_blocks[p])
                send_random_block();
            drain();
        end

        if (tracker.pending() != 0)
            $error("%0d hash words never arrived", tracker.pending());

        $display("Covered %0d blocks from %0d requests, %0d hash words checked;",
                 tracker.blocks_hashed, tracker.words_taken, tracker.words_checked);
        $display("double rounds from 0 to 127, a mid-block rewrite, a %0d-cycle hold-off.",
                 LONG_HOLD);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("tb_salsa20_core_hash OK");
        else
            $display("tb_salsa20_core_hash NOT OK");
        $finish;
    end

endmodule
